// ===== design/fasu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fasu_pkg
// Shared constants, operation codes and leading-one helpers for the
// binary16 add and scale unit.
// ----------------------------------------------------------------------------
package fasu_pkg;

    typedef enum logic [0:0] {
        OP_ADD   = 1'b0,
        OP_SCALE = 1'b1
    } op_t;

    localparam logic [0:0]  REG_SCALE_IDX  = 1'b0;
    localparam logic [31:0] SCALE_RESET    = 32'h3F80_0000;
    localparam logic [14:0] HALF_QNAN_MAG  = 15'h7E00;
    localparam logic [14:0] HALF_INF_MAG   = 15'h7C00;
    localparam logic [15:0] HALF_INF_CODE  = 16'h7C00;
    localparam logic [10:0] SINGLE_BIAS_SUM = 11'd175;

    // Index of the most significant set bit of a 35-bit word.
    function automatic logic [5:0] msb_idx35(input logic [34:0] v);
        logic [5:0] idx;
        begin
            idx = 6'd0;
            for (int i = 0; i < 35; i++)
            begin
                if (v[i])
                begin
                    idx = 6'(i);
                end
            end
            return idx;
        end
    endfunction

    // Index of the most significant set bit of a 41-bit word.
    function automatic logic [5:0] msb_idx41(input logic [40:0] v);
        logic [5:0] idx;
        begin
            idx = 6'd0;
            for (int i = 0; i < 41; i++)
            begin
                if (v[i])
                begin
                    idx = 6'(i);
                end
            end
            return idx;
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/fp16_add_scale_unit_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fp16_add_scale_unit_top
// Binary16 adder and fp32-scale multiplier, four register stages deep.
// ----------------------------------------------------------------------------
// Order: the edge that accepts an item loads the decode stage; the add or
// normalize, round and output registers follow, and the result is then
// shown in m_axis_tdata.
// Throughput: one item per cycle unless stalled; each stage holds only while the
// one after it is full and stalled, so back-pressure costs no bubbles.
// Reset: rst_n clears all valid bits asynchronously and sets scale_reg
// to 1.0; payload registers are not reset.
module fp16_add_scale_unit_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] operand_a, [31:16] operand_b
    input  wire logic [0:0]  s_axis_tuser,   // [0] operation
    input  wire logic        s_axis_tlast,   // is_last
    // Output stream.
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [15:0] m_axis_tdata,   // [15:0] result
    output      logic        m_axis_tlast,   // last_out
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    import fasu_pkg::*;

    // ------------------------------------------------------------------
    // Configuration register. Only the word index in paddr[2] is decoded.
    // ------------------------------------------------------------------
    logic [31:0] scale_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SCALE_IDX);
    assign prdata = (paddr[2] == REG_SCALE_IDX) ? scale_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_wr)
        begin
            scale_reg <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage enables. A stage moves when it is empty or the next one moves.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic en1, en2, en3, en4;

    assign en4 = !out_valid_reg || m_axis_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    // ------------------------------------------------------------------
    // Stage 1: decode both formats, catch special operands, align the add
    // operands to a common fixed point (units of 2^-24) and form the
    // 11 x 24 significand product for scale mode.
    // ------------------------------------------------------------------
    logic [15:0] op_a, op_b;
    logic [4:0]  a_exp, b_exp;
    logic [10:0] a_sig, b_sig;
    logic [7:0]  s_exp;
    logic [23:0] s_sig;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero;
    logic        s_nan, s_inf, s_zero, mul_sign;
    logic [39:0] ma_next, mb_next;
    logic [34:0] prod_next;
    logic [8:0]  esum_next;
    logic        spec_next;
    logic [15:0] spec_res_next;

    assign op_a  = s_axis_tdata[15:0];
    assign op_b  = s_axis_tdata[31:16];
    assign a_exp = op_a[14:10];
    assign b_exp = op_b[14:10];
    assign a_sig = {(a_exp != 5'd0), op_a[9:0]};
    assign b_sig = {(b_exp != 5'd0), op_b[9:0]};
    assign s_exp = scale_reg[30:23];
    assign s_sig = {(s_exp != 8'd0), scale_reg[22:0]};

    assign a_nan  = (a_exp == 5'h1F) && (op_a[9:0] != 10'd0);
    assign b_nan  = (b_exp == 5'h1F) && (op_b[9:0] != 10'd0);
    assign a_inf  = (a_exp == 5'h1F) && (op_a[9:0] == 10'd0);
    assign b_inf  = (b_exp == 5'h1F) && (op_b[9:0] == 10'd0);
    assign a_zero = (op_a[14:0] == 15'd0);
    assign s_nan  = (s_exp == 8'hFF) && (scale_reg[22:0] != 23'd0);
    assign s_inf  = (s_exp == 8'hFF) && (scale_reg[22:0] == 23'd0);
    assign s_zero = (scale_reg[30:0] == 31'd0);
    assign mul_sign = op_a[15] ^ scale_reg[31];

    // Subnormals take the weight of exponent one without the hidden bit.
    assign ma_next = 40'(a_sig) << ((a_exp == 5'd0) ? 5'd0 : (a_exp - 5'd1));
    assign mb_next = 40'(b_sig) << ((b_exp == 5'd0) ? 5'd0 : (b_exp - 5'd1));
    assign prod_next = 35'(a_sig) * 35'(s_sig);
    assign esum_next = 9'((a_exp == 5'd0) ? 5'd1 : a_exp)
                     + 9'((s_exp == 8'd0) ? 8'd1 : s_exp);

    always_comb
    begin
        spec_next     = 1'b1;
        spec_res_next = 16'd0;
        if (s_axis_tuser == OP_ADD)
        begin
            priority if (a_nan)
                spec_res_next = {op_a[15], HALF_QNAN_MAG};
            else if (b_nan)
                spec_res_next = {op_b[15], HALF_QNAN_MAG};
            else if (a_inf && b_inf && (op_a[15] != op_b[15]))
                spec_res_next = {1'b0, HALF_QNAN_MAG};
            else if (a_inf)
                spec_res_next = {op_a[15], HALF_INF_MAG};
            else if (b_inf)
                spec_res_next = {op_b[15], HALF_INF_MAG};
            else
                spec_next = 1'b0;
        end
        else
        begin
            priority if (a_nan)
                spec_res_next = {op_a[15], HALF_QNAN_MAG};
            else if (s_nan)
                spec_res_next = {scale_reg[31], HALF_QNAN_MAG};
            else if ((a_inf && s_zero) || (s_inf && a_zero))
                spec_res_next = {1'b0, HALF_QNAN_MAG};
            else if (a_inf || s_inf)
                spec_res_next = {mul_sign, HALF_INF_MAG};
            else if (a_zero || s_zero)
                spec_res_next = {mul_sign, 15'd0};
            else
                spec_next = 1'b0;
        end
    end

    logic        op1_reg, last1_reg, spec1_reg, sa1_reg, sb1_reg, msign1_reg;
    logic [15:0] spec_res1_reg;
    logic [39:0] ma1_reg, mb1_reg;
    logic [34:0] prod1_reg;
    logic [8:0]  esum1_reg;

    // ------------------------------------------------------------------
    // Stage 2: signed-magnitude add of the aligned operands; leading-one
    // search and left normalization of the product.
    // ------------------------------------------------------------------
    logic [40:0] sum_next;
    logic        add_sign;
    logic [5:0]  prod_msb;
    logic [34:0] pn_next;
    logic signed [10:0] e2_next;

    always_comb
    begin
        if (sa1_reg == sb1_reg)
        begin
            sum_next = 41'(ma1_reg) + 41'(mb1_reg);
            add_sign = sa1_reg;
        end
        else if (ma1_reg >= mb1_reg)
        begin
            sum_next = 41'(ma1_reg - mb1_reg);
            add_sign = sa1_reg;
        end
        else
        begin
            sum_next = 41'(mb1_reg - ma1_reg);
            add_sign = sb1_reg;
        end
        // An exact zero sum is negative only when both addends are.
        if (sum_next == 41'd0)
        begin
            add_sign = sa1_reg && sb1_reg;
        end
    end

    assign prod_msb = msb_idx35(prod1_reg);
    assign pn_next  = prod1_reg << (6'd34 - prod_msb);
    assign e2_next  = signed'(11'(esum1_reg) + 11'(prod_msb) - SINGLE_BIAS_SUM);

    logic        op2_reg, last2_reg, spec2_reg, sgn2_reg;
    logic [15:0] spec_res2_reg;
    logic [40:0] sum2_reg;
    logic [34:0] pn2_reg;
    logic signed [10:0] e2_reg;

    // ------------------------------------------------------------------
    // Stage 3: find the half shift for the sum; round the product to an
    // fp32 significand (nearest even).
    // ------------------------------------------------------------------
    logic [5:0]  sum_msb;
    logic [4:0]  sh3_next;
    logic        f_inc;
    logic [24:0] m25;
    logic [23:0] m3_next;
    logic signed [10:0] e3_next;

    assign sum_msb  = msb_idx41(sum2_reg);
    assign sh3_next = (sum_msb >= 6'd10) ? 5'(sum_msb - 6'd10) : 5'd0;
    assign f_inc    = pn2_reg[10] && ((pn2_reg[9:0] != 10'd0) || pn2_reg[11]);
    assign m25      = {1'b0, pn2_reg[34:11]} + 25'(f_inc);
    assign m3_next  = m25[24] ? 24'h80_0000 : m25[23:0];
    assign e3_next  = m25[24] ? (e2_reg + 11'sd1) : e2_reg;

    logic        op3_reg, last3_reg, spec3_reg, sgn3_reg;
    logic [15:0] spec_res3_reg;
    logic [40:0] sum3_reg;
    logic [4:0]  sh3_reg;
    logic [23:0] m3_reg;
    logic signed [10:0] e3_reg;

    // ------------------------------------------------------------------
    // Stage 4: round to binary16 (nearest even), saturate to infinity.
    // ------------------------------------------------------------------
    logic [40:0] a_shifted, a_rem, a_half;
    logic [15:0] a_q0, a_q;
    logic        a_up;
    logic [14:0] add_mag;

    assign a_shifted = sum3_reg >> sh3_reg;
    assign a_rem     = sum3_reg & ((41'd1 << sh3_reg) - 41'd1);
    assign a_half    = (sh3_reg == 5'd0) ? 41'd0 : (41'd1 << (sh3_reg - 5'd1));
    assign a_q0      = 16'({sh3_reg, 10'd0}) + 16'(a_shifted[10:0]);
    assign a_up      = (sh3_reg != 5'd0)
                    && ((a_rem > a_half) || ((a_rem == a_half) && a_q0[0]));
    assign a_q       = a_q0 + 16'(a_up);
    assign add_mag   = (a_q >= HALF_INF_CODE) ? HALF_INF_MAG : a_q[14:0];

    logic signed [10:0] hex;
    logic [4:0]  m_sh;
    logic [14:0] m_base;
    logic [23:0] m_shifted, m_rem, m_half;
    logic [15:0] m_q0, m_q;
    logic        m_up;
    logic [14:0] mul_mag;

    assign hex       = e3_reg + 11'sd15;
    assign m_sh      = (hex >= 11'sd1) ? 5'd13 : 5'(11'sd14 - hex);
    assign m_base    = (hex >= 11'sd1) ? {5'(hex[4:0] - 5'd1), 10'd0} : 15'd0;
    assign m_shifted = m3_reg >> m_sh;
    assign m_rem     = m3_reg & ((24'd1 << m_sh) - 24'd1);
    assign m_half    = 24'd1 << (m_sh - 5'd1);
    assign m_q0      = 16'(m_base) + 16'(m_shifted[10:0]);
    assign m_up      = (m_rem > m_half) || ((m_rem == m_half) && m_q0[0]);
    assign m_q       = m_q0 + 16'(m_up);

    always_comb
    begin
        priority if (hex >= 11'sd31)
            mul_mag = HALF_INF_MAG;
        else if (hex < -11'sd10)
            mul_mag = 15'd0;
        else
            mul_mag = m_q[14:0];
    end

    logic [15:0] res_next;
    assign res_next = spec3_reg ? spec_res3_reg
                    : {sgn3_reg, (op3_reg == OP_ADD) ? add_mag : mul_mag};

    logic [15:0] out_data_reg;
    logic        out_last_reg;

    // ------------------------------------------------------------------
    // Valid bits.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg        <= s_axis_tvalid;
            if (en2) v2_reg        <= v1_reg;
            if (en3) v3_reg        <= v2_reg;
            if (en4) out_valid_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg       <= s_axis_tuser[0];
            last1_reg     <= s_axis_tlast;
            spec1_reg     <= spec_next;
            spec_res1_reg <= spec_res_next;
            sa1_reg       <= op_a[15];
            sb1_reg       <= op_b[15];
            msign1_reg    <= mul_sign;
            ma1_reg       <= ma_next;
            mb1_reg       <= mb_next;
            prod1_reg     <= prod_next;
            esum1_reg     <= esum_next;
        end
        if (en2)
        begin
            op2_reg       <= op1_reg;
            last2_reg     <= last1_reg;
            spec2_reg     <= spec1_reg;
            spec_res2_reg <= spec_res1_reg;
            sgn2_reg      <= (op1_reg == OP_ADD) ? add_sign : msign1_reg;
            sum2_reg      <= sum_next;
            pn2_reg       <= pn_next;
            e2_reg        <= e2_next;
        end
        if (en3)
        begin
            op3_reg       <= op2_reg;
            last3_reg     <= last2_reg;
            spec3_reg     <= spec2_reg;
            spec_res3_reg <= spec_res2_reg;
            sgn3_reg      <= sgn2_reg;
            sum3_reg      <= sum2_reg;
            sh3_reg       <= sh3_next;
            m3_reg        <= m3_next;
            e3_reg        <= e3_next;
        end
        if (en4)
        begin
            out_data_reg  <= res_next;
            out_last_reg  <= last3_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== design/fasu_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fasu_checker
// Port-level checks for the binary16 add and scale unit.
// ----------------------------------------------------------------------------
module fasu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [31:0] s_axis_tdata,
    input wire logic [0:0]  s_axis_tuser,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("stalled result changed");

    // Every NaN that leaves the block is the canonical quiet pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[14:10] == 5'h1F) && (m_axis_tdata[9:0] != 10'd0)
        |-> m_axis_tdata[9:0] == 10'h200)
        else $error("non-canonical NaN result");

    // A scale write reads back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && !paddr[2]
        |=> paddr[2] || (prdata == $past(pwdata)))
        else $error("scale register readback mismatch");

    // Reset empties the output stage.
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

endmodule

bind fp16_add_scale_unit_top fasu_checker u_fasu_checker (.*);
`default_nettype wire

// ===== test/fp16_add_scale_unit_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fp16_add_scale_unit_top_tb
// Self-checking bench for the binary16 add and scale unit. Items are streamed
// in with random gaps while the output side stalls at random. Each accepted
// item is predicted bit for bit: the exact sum or product is formed in double
// precision, rounded to fp32 and then to binary16, both to nearest even.
// The scale register is rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module fp16_add_scale_unit_top_tb;
    import fasu_pkg::*;

    localparam int CLK_HALF   = 2;
    localparam int CYCLE_CAP  = 600000;
    localparam int DRAIN_WAIT = 12;

    typedef struct packed {
        logic [15:0] result;
        logic        last;
    } half_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [15:0] operand_a, [31:16] operand_b
    logic [0:0]  s_axis_tuser;   // [0] operation
    logic        s_axis_tlast;   // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] result
    logic        m_axis_tlast;   // last_out
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // The bench's own copy of the scale register.
    logic [31:0]  scale_copy;
    half_result_t pending_results[$];
    int           error_count;
    int           cycle_count;
    // When set, the sender offers items back to back.
    bit           burst_mode;
    // When set, the receiver stops taking results for a long stretch.
    bit           hold_request;

    fp16_add_scale_unit_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_HALF) clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Arithmetic helpers used by the predictor.
    // ------------------------------------------------------------------------

    // Exact widening of a binary16 pattern to fp32; subnormals are normalized.
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  ex;
        logic [10:0] man;
        int          shifts;
        begin
            sgn = {h[15], 31'd0};
            ex = h[14:10];
            man = {1'b0, h[9:0]};
            shifts = 0;
            if (ex == 5'd0)
            begin
                if (man == 11'd0)
                begin
                    return sgn;
                end
                while (!man[10])
                begin
                    man = man << 1;
                    shifts++;
                end
                return sgn | (32'(113 - shifts) << 23) | (32'(man[9:0]) << 13);
            end
            if (ex == 5'h1F)
            begin
                return sgn | 32'h7F80_0000 | (32'(man[9:0]) << 13);
            end
            return sgn | (32'(ex + 112) << 23) | (32'(man[9:0]) << 13);
        end
    endfunction

    // Exact widening of a finite fp32 pattern to a double.
    function automatic real single_as_real(input logic [31:0] f);
        logic [23:0] man;
        int          expo;
        logic [10:0] dexp;
        begin
            if (f[30:0] == 31'd0)
            begin
                return $bitstoreal({f[31], 63'd0});
            end
            if (f[30:23] == 8'd0)
            begin
                man = {1'b0, f[22:0]};
                expo = -126;
                while (!man[23])
                begin
                    man = man << 1;
                    expo--;
                end
            end
            else
            begin
                man = {1'b1, f[22:0]};
                expo = int'(f[30:23]) - 127;
            end
            dexp = 11'(expo + 1023);
            return $bitstoreal({f[31], dexp, man[22:0], 29'd0});
        end
    endfunction

    // Rounds a finite double to fp32, nearest even, with subnormals and
    // overflow to infinity.
    function automatic logic [31:0] round_to_single(input real r);
        logic [63:0]     d;
        longint unsigned sig;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned halfway;
        longint unsigned bits;
        int              fexp;
        int              sh;
        begin
            d = $realtobits(r);
            if (d[62:52] == 11'd0)
            begin
                return {d[63], 31'd0};
            end
            sig = {12'd1, d[51:0]};
            fexp = int'(d[62:52]) - 1023 + 127;
            if (fexp >= 1)
            begin
                bits = longint'(fexp - 1) << 23;
                sh = 29;
            end
            else
            begin
                bits = 0;
                sh = 30 - fexp;
            end
            if (sh > 54)
            begin
                q = 0;
            end
            else
            begin
                q = sig >> sh;
                rem = sig & ((64'd1 << sh) - 1);
                halfway = 64'd1 << (sh - 1);
                if (rem > halfway || (rem == halfway && q[0]))
                begin
                    q++;
                end
            end
            bits = bits + q;
            if (bits >= 64'h7F80_0000)
            begin
                bits = 64'h7F80_0000;
            end
            return {d[63], bits[30:0]};
        end
    endfunction

    // Narrows an fp32 pattern to binary16; fp32 subnormals flush to zero.
    function automatic logic [15:0] narrow_single(input logic [31:0] x);
        logic [15:0] sgn;
        logic [31:0] man;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] halfway;
        int          hexp;
        int          sh;
        begin
            sgn = {x[31], 15'd0};
            man = {9'd0, x[22:0]};
            if (x[30:23] == 8'hFF)
            begin
                return sgn | HALF_INF_CODE | ((man != 0) ? 16'h0200 : 16'h0000);
            end
            hexp = int'(x[30:23]) - 112;
            if (hexp >= 31)
            begin
                return sgn | HALF_INF_CODE;
            end
            if (hexp <= 0)
            begin
                if (hexp < -10)
                begin
                    return sgn;
                end
                man = man | 32'h0080_0000;
                sh = 14 - hexp;
                q = man >> sh;
                rem = man & ((32'd1 << sh) - 1);
                halfway = 32'd1 << (sh - 1);
                if (rem > halfway || (rem == halfway && q[0]))
                begin
                    q++;
                end
                return sgn | q[15:0];
            end
            q = (32'(hexp) << 10) | (man >> 13);
            rem = man & 32'h1FFF;
            if (rem > 32'h1000 || (rem == 32'h1000 && q[0]))
            begin
                q++;
            end
            return sgn | q[15:0];
        end
    endfunction

    // Expected binary16 result of one item under the current scale register.
    function automatic logic [15:0] fp16_add_or_scale(input op_t op, input logic [15:0] a,
                                                      input logic [15:0] b,
                                                      input logic [31:0] scale);
        logic a_nan;
        logic b_nan;
        logic a_inf;
        logic b_inf;
        logic s_nan;
        logic s_inf;
        logic a_zero;
        logic s_zero;
        real  exact;
        begin
            a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
            b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
            a_inf = (a[14:0] == HALF_INF_MAG);
            b_inf = (b[14:0] == HALF_INF_MAG);
            a_zero = (a[14:0] == 15'd0);
            s_nan = (scale[30:23] == 8'hFF) && (scale[22:0] != 23'd0);
            s_inf = (scale[30:0] == 31'h7F80_0000);
            s_zero = (scale[30:0] == 31'd0);
            if (a_nan)
            begin
                return {a[15], HALF_QNAN_MAG};
            end
            if (op == OP_ADD)
            begin
                if (b_nan)
                begin
                    return {b[15], HALF_QNAN_MAG};
                end
                if (a_inf && b_inf && (a[15] != b[15]))
                begin
                    return {1'b0, HALF_QNAN_MAG};
                end
                if (a_inf)
                begin
                    return a;
                end
                if (b_inf)
                begin
                    return b;
                end
                exact = single_as_real(widen_half(a)) + single_as_real(widen_half(b));
                return narrow_single(round_to_single(exact));
            end
            if (s_nan)
            begin
                return {scale[31], HALF_QNAN_MAG};
            end
            if ((a_inf && s_zero) || (a_zero && s_inf))
            begin
                return {1'b0, HALF_QNAN_MAG};
            end
            if (a_inf || s_inf)
            begin
                return {a[15] ^ scale[31], HALF_INF_MAG};
            end
            exact = single_as_real(widen_half(a)) * single_as_real(scale);
            return narrow_single(round_to_single(exact));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Shared tasks.
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        begin
            $display("ERROR at cycle %0d: %s got 0x%04h, expected 0x%04h",
                     cycle_count, what, got, want);
            error_count++;
        end
    endtask

    // Mostly short gaps, now and then a long one; none in burst mode.
    function automatic int pick_gap();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (burst_mode || roll < 55)
            begin
                return 0;
            end
            if (roll < 92)
            begin
                return $urandom_range(1, 3);
            end
            return $urandom_range(8, 40);
        end
    endfunction

    task automatic send_item(input op_t op, input logic [15:0] a, input logic [15:0] b,
                             input logic last);
        int gap;
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {b, a};
            s_axis_tuser <= op;
            s_axis_tlast <= last;
            do
            begin
                @(posedge clk);
            end
            while (!s_axis_tready);
        end
    endtask

    task automatic stop_sending();
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // Waits until every expected result has come back, then waits out the drain margin.
    task automatic wait_idle();
        begin
            while (pending_results.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (DRAIN_WAIT) @(posedge clk);
        end
    endtask

    task automatic write_scale(input logic [31:0] value);
        begin
            @(negedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {REG_SCALE_IDX, 2'b00};
            pwdata <= value;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            scale_copy = value;
            @(negedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
    endtask

    // A binary16 pattern biased toward the interesting corners.
    function automatic logic [15:0] pick_half();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                return 16'($urandom());
            end
            if (roll < 65)
            begin
                // Subnormals and zeros.
                return {1'($urandom()), 5'd0, 10'($urandom())};
            end
            if (roll < 80)
            begin
                // Near the top of the range, where overflow lives.
                return {1'($urandom()), 5'($urandom_range(28, 30)), 10'($urandom())};
            end
            if (roll < 90)
            begin
                // Infinities and NaNs.
                return {1'($urandom()), 5'h1F, ($urandom_range(0, 2) == 0) ? 10'd0
                                                                          : 10'($urandom())};
            end
            return {1'($urandom()), 5'($urandom_range(10, 20)), 10'($urandom())};
        end
    endfunction

    // An fp32 scale, mostly of moderate size so that results stay in range.
    function automatic logic [31:0] pick_scale();
        int roll;
        begin
            roll = $urandom_range(0, 9);
            if (roll < 6)
            begin
                return {1'($urandom()), 8'($urandom_range(100, 150)), 23'($urandom())};
            end
            if (roll < 8)
            begin
                return $urandom();
            end
            return {1'($urandom()), 8'd0, 23'($urandom())};
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Corner cases of the add path at the reset scale of 1.0.
    task automatic test_add_corners();
        begin
            send_item(OP_ADD, 16'h0000, 16'h0000, 1'b0);
            send_item(OP_ADD, 16'h8000, 16'h8000, 1'b0);
            send_item(OP_ADD, 16'h0000, 16'h8000, 1'b0);
            send_item(OP_ADD, 16'h7BFF, 16'h7BFF, 1'b0);
            send_item(OP_ADD, 16'hFBFF, 16'hFBFF, 1'b1);
            send_item(OP_ADD, 16'h7C00, 16'hFC00, 1'b0);
            send_item(OP_ADD, 16'hFC00, 16'h3C00, 1'b0);
            send_item(OP_ADD, 16'hFE01, 16'h7C01, 1'b0);
            send_item(OP_ADD, 16'h3C00, 16'hFFFF, 1'b0);
            send_item(OP_ADD, 16'h0001, 16'h0001, 1'b0);
            send_item(OP_ADD, 16'h0001, 16'h8001, 1'b0);
            send_item(OP_ADD, 16'h3C00, 16'h0001, 1'b0);
            send_item(OP_ADD, 16'h03FF, 16'h0001, 1'b1);
            send_item(OP_ADD, 16'hFFFF, 16'hFFFF, 1'b1);
            stop_sending();
            wait_idle();
        end
    endtask

    // Scale path across extreme register values, each with a few operands.
    task automatic test_scale_corners();
        logic [31:0] scales[8];
        begin
            scales = '{32'h3F80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                       32'h7F80_0000, 32'h0000_0000, 32'h8000_0000, 32'h3380_0000};
            foreach (scales[i])
            begin
                write_scale(scales[i]);
                send_item(OP_SCALE, 16'h3C00, 16'hFFFF, 1'b0);
                send_item(OP_SCALE, 16'h0001, 16'h0000, 1'b0);
                send_item(OP_SCALE, 16'h7C00, 16'h0000, 1'b0);
                send_item(OP_SCALE, 16'h8000, 16'h0000, 1'b0);
                send_item(OP_SCALE, 16'hFE00, 16'h0000, 1'b1);
                stop_sending();
                wait_idle();
            end
        end
    endtask

    // Random mixed items over several scale settings.
    task automatic test_random_mix(input int n_phases, input int per_phase);
        op_t op;
        begin
            for (int p = 0; p < n_phases; p++)
            begin
                write_scale(pick_scale());
                burst_mode = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < per_phase; i++)
                begin
                    op = op_t'($urandom_range(0, 1));
                    send_item(op, pick_half(), pick_half(), 1'($urandom()));
                end
                stop_sending();
                burst_mode = 1'b0;
                wait_idle();
            end
        end
    endtask

    // The receiver holds off while items keep coming, filling the pipeline.
    task automatic test_backpressure();
        begin
            write_scale(32'h4000_0000);
            burst_mode = 1'b1;
            hold_request = 1'b1;
            for (int i = 0; i < 60; i++)
            begin
                send_item(op_t'($urandom_range(0, 1)), pick_half(), pick_half(),
                          1'($urandom()));
            end
            stop_sending();
            burst_mode = 1'b0;
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Processes.
    // ------------------------------------------------------------------------

    // Predict every item at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            pending_results.push_back('{
                result: fp16_add_or_scale(op_t'(s_axis_tuser[0]), s_axis_tdata[15:0],
                                          s_axis_tdata[31:16], scale_copy),
                last:   s_axis_tlast});
        end
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        half_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("ERROR at cycle %0d: result 0x%04h with nothing expected",
                         cycle_count, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.result)
                begin
                    report_mismatch("result", m_axis_tdata, want.result);
                end
                if (m_axis_tlast !== want.last)
                begin
                    report_mismatch("last_out", 16'(m_axis_tlast), 16'(want.last));
                end
            end
        end
    end

    // Receiver: random stalls, runs of always-ready, and on request a long hold.
    initial
    begin
        int roll;
        int run;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                begin
                    run = $urandom_range(1, 30);
                    m_axis_tready <= 1'b1;
                end
                else if (roll < 90)
                begin
                    run = $urandom_range(1, 3);
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    run = $urandom_range(8, 40);
                    m_axis_tready <= 1'b0;
                end
                repeat (run - 1) @(negedge clk);
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 32'd0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        scale_copy = SCALE_RESET;
        error_count = 0;
        cycle_count = 0;
        burst_mode = 1'b0;
        hold_request = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_add_corners();
        test_scale_corners();
        test_backpressure();
        test_random_mix(20, 95);

        wait_idle();
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/fasu_pkg.sv
design/fp16_add_scale_unit_top.sv
design/fasu_checker.sv
test/fp16_add_scale_unit_top_tb.sv
